### rtl/core/fbsc_pkg.sv
// ----------------------------------------------------------------------------
// fbsc_pkg
// Types, codes and constants shared by the frame byte stuffing codec.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    localparam int CNT_W     = 17;
    localparam int LEN_W     = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // frame-end status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD_CODE = 2'd2;
    localparam logic [1:0] ST_TRAIL    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAD      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_ESC  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_HEAD = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_TAIL = 8'd7;

    typedef enum logic {
        MODE_ESCAPE   = 1'b0,
        MODE_UNESCAPE = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [LEN_W-1:0]  max_len;
        logic [7:0]        head_marker;
        logic [7:0]        tail_marker;
        logic [7:0]        escape_marker;
        logic [7:0]        code_for_escape;
        logic [7:0]        code_for_head;
        logic [7:0]        code_for_tail;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic [1:0] status;
    } res_t;

    // one queue entry: up to two results caused by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } entry_t;

    localparam res_t RES_NONE = '{out_byte: 8'd0, byte_valid: 1'b0,
                                  frame_end: 1'b0, status: ST_OK};

endpackage

### rtl/core/fbsc_front.sv
// ----------------------------------------------------------------------------
// fbsc_front
// Accepts input bytes, keeps the per-frame state and turns each byte into
// a queue entry of zero, one or two results.
// ----------------------------------------------------------------------------
module fbsc_front
    import fbsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       q_full,
    output logic       in_ready,
    output logic       push,
    output entry_t     push_entry
);

    logic             esc_pend_reg,  esc_pend_next;
    logic             failed_reg,    failed_next;
    logic [1:0]       fail_kind_reg, fail_kind_next;
    logic [CNT_W-1:0] seen_reg,      seen_next;
    logic [CNT_W-1:0] added_reg,     added_next;

    logic             accept;
    logic             is_esc;
    logic [7:0]       code;
    logic [CNT_W-1:0] seen_inc, added_inc;
    logic [CNT_W:0]   total;
    logic [1:0]       ovf_st;
    entry_t           ent;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // marker match in escape mode: head first, then escape, then tail
    always_comb begin
        is_esc = 1'b1;
        code   = 8'd0;
        priority if (in_byte == cfg.head_marker) begin
            code = cfg.code_for_head;
        end else if (in_byte == cfg.escape_marker) begin
            code = cfg.code_for_escape;
        end else if (in_byte == cfg.tail_marker) begin
            code = cfg.code_for_tail;
        end else begin
            is_esc = 1'b0;
        end
    end

    assign seen_inc  = (seen_reg != CNT_MAX) ? seen_reg + 1'b1 : seen_reg;
    assign added_inc = (is_esc && added_reg != CNT_MAX) ? added_reg + 1'b1 : added_reg;
    assign total     = {1'b0, seen_inc} + {1'b0, added_inc} + 1'b1;
    assign ovf_st    = (in_last && added_inc != '0 && total > {2'b00, cfg.max_len})
                       ? ST_OVERFLOW : ST_OK;

    always_comb begin
        esc_pend_next  = esc_pend_reg;
        failed_next    = failed_reg;
        fail_kind_next = fail_kind_reg;
        seen_next      = seen_reg;
        added_next     = added_reg;
        ent            = '{cnt: 2'd0, r0: RES_NONE, r1: RES_NONE};

        if (cfg.mode == MODE_ESCAPE) begin
            seen_next  = seen_inc;
            added_next = added_inc;
            if (is_esc) begin
                ent.cnt = 2'd2;
                ent.r0  = '{out_byte: cfg.escape_marker, byte_valid: 1'b1,
                            frame_end: 1'b0, status: ST_OK};
                ent.r1  = '{out_byte: code, byte_valid: 1'b1,
                            frame_end: in_last, status: ovf_st};
            end else begin
                ent.cnt = 2'd1;
                ent.r0  = '{out_byte: in_byte, byte_valid: 1'b1,
                            frame_end: in_last, status: ovf_st};
            end
        end else if (failed_reg) begin
            // drop the rest of a failed frame, report at its end
            if (in_last) begin
                ent.cnt = 2'd1;
                ent.r0  = '{out_byte: 8'd0, byte_valid: 1'b0,
                            frame_end: 1'b1, status: fail_kind_reg};
            end
        end else if (esc_pend_reg) begin
            esc_pend_next = 1'b0;
            ent.cnt       = 2'd1;
            priority if (in_byte == cfg.code_for_escape) begin
                ent.r0 = '{out_byte: cfg.escape_marker, byte_valid: 1'b1,
                           frame_end: in_last, status: ST_OK};
            end else if (in_byte == cfg.code_for_head) begin
                ent.r0 = '{out_byte: cfg.head_marker, byte_valid: 1'b1,
                           frame_end: in_last, status: ST_OK};
            end else if (in_byte == cfg.code_for_tail) begin
                ent.r0 = '{out_byte: cfg.tail_marker, byte_valid: 1'b1,
                           frame_end: in_last, status: ST_OK};
            end else begin
                failed_next    = 1'b1;
                fail_kind_next = ST_BAD_CODE;
                ent.cnt        = in_last ? 2'd1 : 2'd0;
                ent.r0         = '{out_byte: 8'd0, byte_valid: 1'b0,
                                   frame_end: 1'b1, status: ST_BAD_CODE};
            end
        end else if (in_byte == cfg.escape_marker) begin
            esc_pend_next = 1'b1;
            ent.cnt       = in_last ? 2'd1 : 2'd0;
            ent.r0        = '{out_byte: 8'd0, byte_valid: 1'b0,
                              frame_end: 1'b1, status: ST_TRAIL};
        end else begin
            ent.cnt = 2'd1;
            ent.r0  = '{out_byte: in_byte, byte_valid: 1'b1,
                        frame_end: in_last, status: ST_OK};
        end

        // every last byte closes the frame in either mode
        if (in_last) begin
            esc_pend_next  = 1'b0;
            failed_next    = 1'b0;
            fail_kind_next = ST_OK;
            seen_next      = '0;
            added_next     = '0;
        end
    end

    assign push       = accept && (ent.cnt != 2'd0);
    assign push_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_pend_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            fail_kind_reg <= ST_OK;
            seen_reg      <= '0;
            added_reg     <= '0;
        end else if (accept) begin
            esc_pend_reg  <= esc_pend_next;
            failed_reg    <= failed_next;
            fail_kind_reg <= fail_kind_next;
            seen_reg      <= seen_next;
            added_reg     <= added_next;
        end
    end

endmodule

### rtl/core/fbsc_queue.sv
// ----------------------------------------------------------------------------
// fbsc_queue
// Short entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module fbsc_queue
    import fbsc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    entry_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg,  count_next;

    assign full      = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/fbsc_back.sv
// ----------------------------------------------------------------------------
// fbsc_back
// Takes queue entries and plays out their results one per cycle through
// an output register while out_ready does not hold the output.
// ----------------------------------------------------------------------------
module fbsc_back
    import fbsc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_not_empty,
    input  entry_t q_head,
    output logic   pop,
    input  logic   out_ready,
    output logic   out_valid,
    output res_t   out_res
);

    entry_t hold_reg,       hold_next;
    logic   hold_valid_reg, hold_valid_next;
    logic   sel_reg,        sel_next;
    logic   out_valid_reg,  out_valid_next;
    res_t   out_res_reg,    out_res_next;

    logic   out_free;
    logic   send;
    logic   hold_done;

    assign out_free  = !out_valid_reg || out_ready;
    assign send      = out_free && hold_valid_reg;
    assign hold_done = send && (sel_reg || hold_reg.cnt != 2'd2);
    assign pop       = q_not_empty && (!hold_valid_reg || hold_done);

    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        sel_next        = sel_reg;
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;

        if (send) begin
            out_valid_next = 1'b1;
            out_res_next   = sel_reg ? hold_reg.r1 : hold_reg.r0;
            sel_next       = 1'b1;
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end

        if (pop) begin
            hold_next       = q_head;
            hold_valid_next = 1'b1;
            sel_next        = 1'b0;
        end else if (hold_done) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg    <= hold_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            sel_reg        <= sel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

### rtl/core/frame_byte_stuffing_codec.sv
// ----------------------------------------------------------------------------
// frame_byte_stuffing_codec
// Byte stuffing / unstuffing codec for framed byte streams.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle on the s_ stream (tlast marks the final
// byte) and emits result bytes on the m_ stream, one result per cycle while
// m_tready is high. In escape mode a head, escape or tail marker byte yields
// two results (escape byte, then its code); every other byte yields one, and
// a byte in unescape mode yields at most one. A four-entry queue between the
// input classifier and the output player absorbs the extra results of
// escaped bytes, so the input only stalls when the queue fills. m_tuser
// carries byte_valid and status; a result with byte_valid low is a status-only
// result at frame end. Write configuration through cfg_* only while the block
// is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module frame_byte_stuffing_codec
    import fbsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // last_byte
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic [2:0]           m_tuser,   // [0] byte_valid, [2:1] status
    output logic                 m_tlast    // frame_end
);

    cfg_t   cfg_reg, cfg_next;
    logic   q_full, q_not_empty, q_push, q_pop;
    entry_t q_in, q_head;
    res_t   out_res;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                REG_MODE:      cfg_next.mode            = mode_t'(cfg_wdata[0]);
                REG_MAX_LEN:   cfg_next.max_len         = cfg_wdata;
                REG_HEAD:      cfg_next.head_marker     = cfg_wdata[7:0];
                REG_TAIL:      cfg_next.tail_marker     = cfg_wdata[7:0];
                REG_ESCAPE:    cfg_next.escape_marker   = cfg_wdata[7:0];
                REG_CODE_ESC:  cfg_next.code_for_escape = cfg_wdata[7:0];
                REG_CODE_HEAD: cfg_next.code_for_head   = cfg_wdata[7:0];
                REG_CODE_TAIL: cfg_next.code_for_tail   = cfg_wdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: MODE_ESCAPE, max_len: 16'hFFFF,
                         head_marker: 8'd126, tail_marker: 8'd127,
                         escape_marker: 8'd125, code_for_escape: 8'd1,
                         code_for_head: 8'd2, code_for_tail: 8'd3};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fbsc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .in_ready   (s_tready),
        .push       (q_push),
        .push_entry (q_in)
    );

    fbsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    fbsc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (q_pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_res     (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.status, out_res.byte_valid};
    assign m_tlast = out_res.frame_end;

endmodule
